// ===== design/lowpass_feedback_comb_filter_top_assert.svh =====
// Assertion macros for the lowpass feedback comb filter checker.
// Expects clk and arst_n in the scope of each use.
`ifndef LOWPASS_FEEDBACK_COMB_FILTER_TOP_ASSERT_SVH
`define LOWPASS_FEEDBACK_COMB_FILTER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define LFCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons starting in the cycle after ante.
`define LFCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lfcf_pkg.sv =====
// Shared types and constants of the lowpass feedback comb filter.
// No dependencies; used by the register file, sequencer, datapath and top level.
package lfcf_pkg;

	localparam int DELAY_W    = 16;
	localparam int GAIN_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Q1.15 unity and rounding half
	localparam logic [15:0] ONE_Q15  = 16'h8000;
	localparam int          RND_HALF = 16384;
	localparam int          Q_SHIFT  = 15;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LPF_EN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LPF_GAIN = 2'd3;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_samples;
		logic [GAIN_W-1:0]  comb_gain;
		logic               lpf_enable;
		logic [GAIN_W-1:0]  lpf_gain;
	} cfg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_WRITE
	} state_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic commit;
	} cmd_t;

endpackage

// ===== design/lfcf_regs.sv =====
// Configuration register file of the comb filter.
// Depends on lfcf_pkg.
module lfcf_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lfcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output lfcf_pkg::cfg_t                  cfg
);
	import lfcf_pkg::*;

	cfg_t cfg_q;

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_samples <= DELAY_W'(1);
			cfg_q.comb_gain     <= '0;
			cfg_q.lpf_enable    <= 1'b0;
			cfg_q.lpf_gain      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY:    cfg_q.delay_samples <= cfg_wdata[DELAY_W-1:0];
				REG_GAIN:     cfg_q.comb_gain     <= cfg_wdata[GAIN_W-1:0];
				REG_LPF_EN:   cfg_q.lpf_enable    <= cfg_wdata[0];
				REG_LPF_GAIN: cfg_q.lpf_gain      <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/lfcf_ctrl.sv =====
// Sequencer of the comb filter: steps one sample through read, two
// multiplies and write-back, and owns both handshakes. Depends on lfcf_pkg.
module lfcf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output lfcf_pkg::cmd_t cmd
);
	import lfcf_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = S_WRITE;
			end
			S_WRITE: begin
				// hold until the output register can take the beat
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== design/lfcf_dpath.sv =====
// Datapath of the comb filter: delay memory, pointer, damping state,
// multipliers with Q15 rounding, saturation and the output register.
// Depends on lfcf_pkg.
module lfcf_dpath #(
	parameter int MAX_DELAY    = 65536,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfcf_pkg::cmd_t          cmd,
	input  lfcf_pkg::cfg_t          cfg,
	input  logic [SAMPLE_WIDTH-1:0] sample_in,
	output logic [SAMPLE_WIDTH-1:0] sample_out
);
	import lfcf_pkg::*;

	localparam int SW   = SAMPLE_WIDTH;
	localparam int AW   = $clog2(MAX_DELAY);
	localparam int DW   = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
	localparam int PW   = SW + 16;
	localparam int SUMW = SW + 2;
	localparam int G2W  = 2 * GAIN_W + 1;
	localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] SMIN = ~SMAX;

	function automatic logic [SW-1:0] sat_fn(input logic signed [SUMW-1:0] v);
		if (v > SMAX) begin
			return SMAX[SW-1:0];
		end
		if (v < SMIN) begin
			return SMIN[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	logic [SW-1:0]        mem_q [MAX_DELAY];
	logic [AW-1:0]        wp_q;
	logic                 wrapped_q;
	logic signed [SW-1:0] damp_q;
	logic [SW-1:0]        out_q;

	logic [SW-1:0]        rdata_s1;
	logic                 rdv_s1;
	logic signed [SW-1:0] x_s1;
	logic [G2W-1:0]       g2p_s1;
	logic signed [SW-1:0] yn_s2;
	logic signed [PW-1:0] prod1_s2;
	logic signed [SW-1:0] filt_s3;
	logic signed [PW-1:0] prod2_s3;

	logic [DW-1:0]          d_eff;
	logic [DW-1:0]          wp_ext;
	logic                   wp_ge;
	logic [DW-1:0]          rd_full;
	logic [AW-1:0]          rd_addr;
	logic [15:0]            one_minus_g;
	logic [G2W-1:0]         g2_sum;
	logic [GAIN_W-1:0]      g2;
	logic signed [15:0]     g2_s;
	logic signed [15:0]     cg_s;
	logic signed [SW-1:0]   yn;
	logic signed [PW-1:0]   t1;
	logic signed [SW:0]     r1;
	logic signed [SW-1:0]   filtered;
	logic signed [PW-1:0]   t2;
	logic signed [SW:0]     r2;
	logic [SW-1:0]          wr_data;

	// Clamp delay to 1..MAX_DELAY and form the read address
	always_comb begin
		d_eff = DW'(cfg.delay_samples);
		if (cfg.delay_samples == '0) begin
			d_eff = DW'(1);
		end
		if (d_eff > DW'(MAX_DELAY)) begin
			d_eff = DW'(MAX_DELAY);
		end
	end

	assign wp_ext  = DW'(wp_q);
	assign wp_ge   = (wp_ext >= d_eff);
	assign rd_full = wp_ge ? (wp_ext - d_eff) : (wp_ext + DW'(MAX_DELAY) - d_eff);
	assign rd_addr = rd_full[AW-1:0];

	// Lowpass coefficient scaled by (1 - comb gain)
	assign one_minus_g = ONE_Q15 - 16'(cfg.comb_gain);
	assign g2_sum      = g2p_s1 + G2W'(RND_HALF);
	assign g2          = g2_sum[Q_SHIFT +: GAIN_W];
	assign g2_s        = {1'b0, g2};
	assign cg_s        = {1'b0, cfg.comb_gain};

	// Entries not written since reset read as zero
	assign yn = rdv_s1 ? signed'(rdata_s1) : '0;

	// Damping sum, rounded and saturated; bypassed when the lowpass is off
	assign t1       = prod1_s2 + PW'(RND_HALF);
	assign r1       = t1[PW-1:Q_SHIFT];
	assign filtered = cfg.lpf_enable ? signed'(sat_fn(SUMW'(yn_s2) + SUMW'(r1))) : yn_s2;

	// Write-back value
	assign t2      = prod2_s3 + PW'(RND_HALF);
	assign r2      = t2[PW-1:Q_SHIFT];
	assign wr_data = sat_fn(SUMW'(x_s1) + SUMW'(r2));

	// Delay memory: read on accept, write on commit
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_s1 <= mem_q[rd_addr];
		end
		if (cmd.commit) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_s1   <= signed'(sample_in);
			rdv_s1 <= wrapped_q || wp_ge;
			g2p_s1 <= G2W'(cfg.lpf_gain) * G2W'(one_minus_g);
		end
		if (cmd.mul1) begin
			yn_s2    <= yn;
			prod1_s2 <= PW'(damp_q) * PW'(g2_s);
		end
		if (cmd.mul2) begin
			filt_s3  <= filtered;
			prod2_s3 <= PW'(filtered) * PW'(cg_s);
		end
		if (cmd.commit) begin
			out_q <= yn_s2;
		end
	end

	// Advance write pointer, track first wrap, update damping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			damp_q    <= '0;
		end else if (cmd.commit) begin
			if (wp_q == AW'(MAX_DELAY - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
			if (cfg.lpf_enable) begin
				damp_q <= filt_s3;
			end
		end
	end

	assign sample_out = out_q;

endmodule

// ===== design/lowpass_feedback_comb_filter_top.sv =====
// Lowpass feedback comb filter, top level. An accepted input beat passes the
// sequencer's memory read, two dependent multiplies and write-back before its
// result beat is registered; a new sample is taken only once the last is
// written back, and a stalled output holds the sequencer in its write step.
// Reset: asynchronous; the delay memory needs no clearing pass, since
// entries not yet written since reset read as zero.
module lowpass_feedback_comb_filter_top #(
	parameter int MAX_DELAY    = 65536,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_in, zero padding above
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_out, zero padding above
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
	input  logic                                   cfg_we,
	input  logic [lfcf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lfcf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import lfcf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	cfg_t                    cfg;
	cmd_t                    cmd;
	logic [SAMPLE_WIDTH-1:0] sample_out;

	lfcf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lfcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	lfcf_dpath #(
		.MAX_DELAY    (MAX_DELAY),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.sample_out (sample_out)
	);

	assign m_axis_tdata = TDATA_W'(sample_out);

endmodule

// ===== design/lfcf_checker.sv =====
// Port-level checker of the comb filter, bound to the top level.
// Depends on lowpass_feedback_comb_filter_top_assert.svh.
`include "lowpass_feedback_comb_filter_top_assert.svh"

module lfcf_checker #(
	parameter int TDATA_W = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata
);

	// A stalled result beat stays valid
	`LFCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")

	// A stalled result beat keeps its data
	`LFCF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out data changed")

	// One sample in flight: no new beat is taken through the multiply and write steps after an accept
	`LFCF_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready, "beat taken while busy")

	// A fresh result must trace back to an accepted input beat, past the read, multiply and write steps
	`LFCF_ASSERT_NOW(a_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 4), "result without matching input")

endmodule

bind lowpass_feedback_comb_filter_top lfcf_checker #(
	.TDATA_W (TDATA_W)
) u_lfcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lowpass_feedback_comb_filter_top: a directed table, then random
// phases of settings and samples under changing backpressure. Depends on lfcf_pkg and the RTL.
module tb_top;
	import lfcf_pkg::*;

	localparam int DATA_W      = 16;
	localparam int SETTLE      = 6;     // longer than the filter's input-to-result latency
	localparam int HOLD_CYCLES = 200;   // long receiver hold-off
	localparam int WDOG_LIMIT  = 4000;  // cycles with no beat or register write before giving up
	localparam int N_PHASES    = 24;
	localparam int PHASE_LEN   = 60;

	typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;     // register, for ROW_CFG
		logic [DATA_W-1:0]     val;     // sample or register value
		bit                    typed;   // expected output given below
		logic [DATA_W-1:0]     exp_out;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [15:0] sample_in
	logic [DATA_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [15:0] sample_out
	logic [DATA_W-1:0]     m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// bench-side copy of the filter: registers, delay line, pointer, damping state
	logic [DELAY_W-1:0]    cfg_delay   = 16'd1;
	logic [GAIN_W-1:0]     cfg_gain    = '0;
	logic                  cfg_lpf_en  = 1'b0;
	logic [GAIN_W-1:0]     cfg_lpf_gain = '0;
	bit   [DATA_W-1:0]     delay_line [0:65535];
	logic [DELAY_W-1:0]    wr_addr     = '0;
	logic signed [DATA_W-1:0] damp_state = '0;

	logic [DATA_W-1:0]     pending_out_q [$];
	bit                    drv_typed;
	logic [DATA_W-1:0]     drv_exp;
	int                    src_gap_pct   = 0;
	int                    sink_stall_pct = 0;
	int                    hold_req      = 0;
	int                    hold_ack      = 0;
	int                    err_cnt       = 0;
	int                    n_in          = 0;
	int                    n_out         = 0;
	int                    n_settings    = 0;
	int                    idle_cycles   = 0;

	// reset, extremes of the sample range, zero and maximum delay, saturation both ways,
	// lowpass with zero comb gain, lowpass switched off and back on
	dir_row_t dir_tbl [34] = '{
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b1, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b1, 16'h7FFF},
		'{ROW_SAMPLE, '0,           16'hFFFF, 1'b1, 16'h8000},
		'{ROW_SAMPLE, '0,           16'h0000, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, '0,           16'h0001, 1'b1, 16'h0000},
		'{ROW_CFG,    REG_DELAY,    16'h0000, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_GAIN,     16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b1, 16'h0001},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_LPF_EN,   16'h0001, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_LPF_GAIN, 16'h7FFF, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_GAIN,     16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h4000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'hC000, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_GAIN,     16'h4000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h8000, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_LPF_EN,   16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h1234, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'hEDCB, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_LPF_EN,   16'h0001, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h7FFF, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_DELAY,    16'hFFFF, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h5555, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'hAAAA, 1'b0, 16'h0000},
		'{ROW_CFG,    REG_DELAY,    16'h0002, 1'b0, 16'h0000},
		'{ROW_SAMPLE, '0,           16'h0000, 1'b0, 16'h0000}
	};

	lowpass_feedback_comb_filter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q15 product scaling, round half up
	function automatic longint q15_round(input longint p);
		return (p + RND_HALF) >>> Q_SHIFT;
	endfunction

	function automatic longint clamp_sample(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Read the delayed sample, write back input plus (damped) feedback, advance the pointer
	function automatic logic [DATA_W-1:0] comb_filter_step(input logic [DATA_W-1:0] smp);
		logic [DELAY_W-1:0] lag;
		logic [DELAY_W-1:0] rd_addr;
		longint x;
		longint echo;
		longint g2;
		longint damped;
		longint fb;
		lag     = (cfg_delay == '0) ? 16'd1 : cfg_delay;
		rd_addr = wr_addr - lag;
		x       = longint'($signed(smp));
		echo    = longint'($signed(delay_line[rd_addr]));
		if (cfg_lpf_en) begin
			g2     = q15_round(longint'(cfg_lpf_gain) *
				(longint'(ONE_Q15) - longint'(cfg_gain)));
			damped = clamp_sample(echo + q15_round(longint'(damp_state) * g2));
			fb     = clamp_sample(x + q15_round(damped * longint'(cfg_gain)));
			damp_state = damped[DATA_W-1:0];
		end else begin
			fb = clamp_sample(x + q15_round(echo * longint'(cfg_gain)));
		end
		delay_line[rd_addr + lag] = fb[DATA_W-1:0];
		wr_addr = wr_addr + 16'd1;
		return echo[DATA_W-1:0];
	endfunction

	// Track register writes, predict on each input beat, check each output beat
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		logic [DATA_W-1:0] pred;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DELAY:    cfg_delay    = cfg_wdata[DELAY_W-1:0];
					REG_GAIN:     cfg_gain     = cfg_wdata[GAIN_W-1:0];
					REG_LPF_EN:   cfg_lpf_en   = cfg_wdata[0];
					REG_LPF_GAIN: cfg_lpf_gain = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pred = comb_filter_step(s_axis_tdata);
				pending_out_q.push_back(drv_typed ? drv_exp : pred);
				n_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_out++;
				if (pending_out_q.size() == 0) begin
					$error("sample_out: beat %h with nothing expected", m_axis_tdata);
					err_cnt++;
				end else begin
					want = pending_out_q.pop_front();
					if (m_axis_tdata !== want) begin
						$error("sample_out: expected %h, actual %h", want, m_axis_tdata);
						err_cnt++;
					end
				end
			end
		end
	end

	// Watchdog: give up when no beat or register write moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
			(m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$error("no beat moved for %0d cycles", WDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offer one sample, with a random gap first; returns at the falling edge after the beat
	task automatic send_sample(input logic [DATA_W-1:0] smp, input bit typed,
		input logic [DATA_W-1:0] exp_val);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct)
			@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = smp;
		drv_typed     = typed;
		drv_exp       = exp_val;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Hold the input until every expected sample is out, then let the block settle
	task automatic wait_drained();
		while (pending_out_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// New settings for a phase: mostly short delays and strong feedback, extremes now and then
	task automatic pick_settings();
		logic [15:0] dly;
		logic [15:0] gain;
		logic [15:0] lgain;
		case ($urandom_range(9))
			0:       dly = 16'h0000;
			1:       dly = 16'hFFFF;
			2:       dly = 16'h0001;
			3:       dly = 16'($urandom);
			default: dly = 16'($urandom_range(48, 2));
		endcase
		case ($urandom_range(7))
			0:       gain = 16'h0000;
			1:       gain = 16'h7FFF;
			2:       gain = 16'($urandom);
			default: gain = 16'($urandom_range(32767, 16384));
		endcase
		case ($urandom_range(5))
			0:       lgain = 16'h0000;
			1:       lgain = 16'h7FFF;
			default: lgain = 16'($urandom);
		endcase
		write_reg(REG_DELAY, dly);
		write_reg(REG_GAIN, gain);
		write_reg(REG_LPF_GAIN, lgain);
		write_reg(REG_LPF_EN,
			16'({$urandom_range(15), 1'b0}) | 16'($urandom_range(3) != 0));
		n_settings++;
	endtask

	function automatic logic [DATA_W-1:0] rand_sample();
		case ($urandom_range(9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		drv_typed     = 1'b0;
		drv_exp       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, no idling
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_tbl[i].idx, dir_tbl[i].val);
			end else begin
				send_sample(dir_tbl[i].val, dir_tbl[i].typed, dir_tbl[i].exp_out);
			end
		end
		n_settings++;

		// Random phases; idling mode rotates with the phase
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			pick_settings();
			case (ph % 4)
				0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_gap_pct = 72; sink_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct = 72; end
				default: begin src_gap_pct = 7; sink_stall_pct = 7; end
			endcase
			for (int k = 0; k < PHASE_LEN; k++) begin
				// block the output for a while and keep offering input so it backs up
				if (ph % 8 == 4 && k == 20)
					hold_req++;
				// pause input until everything has come out
				if (ph % 8 == 1 && k == 30)
					wait_drained();
				send_sample(rand_sample(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (4 * SETTLE) @(negedge clk);
		if (pending_out_q.size() != 0) begin
			$error("sample_out: %0d expected beats never arrived", pending_out_q.size());
			err_cnt++;
		end
		$display("Ran %0d samples through %0d filter settings, %0d output beats checked.",
			n_in, n_settings, n_out);
		$display("Idling modes: none, input gaps, output stalls, both; %0d errors.", err_cnt);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
